FILE: rtl/core/efra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_pkg: shared types and constants for the Euler force rotator
// Field widths, CORDIC constants, the queue record passed front to back and
// the request/response records of the shared CORDIC unit.
// ----------------------------------------------------------------------------
package efra_pkg;

  localparam int FORCE_BITS    = 32;
  localparam int ANGLE_FIELD_W = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int TRIG_BITS     = 16;
  localparam int SUM_BITS      = 40;
  localparam int OUT_W         = 32;

  // Input tdata layout, lowest bit first
  localparam int IN_FX_LSB    = 0;
  localparam int IN_FY_LSB    = FORCE_BITS;
  localparam int IN_FZ_LSB    = 2 * FORCE_BITS;
  localparam int IN_PITCH_LSB = 3 * FORCE_BITS;
  localparam int IN_YAW_LSB   = IN_PITCH_LSB + ANGLE_FIELD_W;
  localparam int IN_ROLL_LSB  = IN_YAW_LSB + ANGLE_FIELD_W;
  localparam int IN_DATA_W    = IN_ROLL_LSB + ANGLE_FIELD_W;
  localparam int OUT_DATA_W   = 6 * OUT_W;

  // Binary angle as a 32 bit turn; only the top ANGLE_BITS survive
  localparam int          TURN_W      = 32;
  localparam logic [31:0] TURN_KEEP   = 32'hFFFF_FFFF << (TURN_W - ANGLE_BITS);
  localparam logic [15:0] ANGLE_KEEP  = TURN_KEEP[31:16];

  // CORDIC work registers: Q30 with headroom
  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_CYCLE = 2;
  localparam int CORDIC_CYCLES   = CORDIC_STEPS / STEPS_PER_CYCLE;
  localparam int CYC_CNT_W       = $clog2(CORDIC_CYCLES);
  localparam int STEP_IDX_W      = $clog2(CORDIC_STEPS);
  localparam int CORDIC_W        = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam int TRIG_SHIFT      = TURN_W - TRIG_BITS;
  localparam logic signed [CORDIC_W-1:0] TRIG_HALF =
      CORDIC_W'(1) << (TRIG_SHIFT - 1);
  localparam int TRIG_W          = TRIG_BITS + 2;

  // Rotation products
  localparam int ROT_FRAC = TRIG_BITS - 2;
  localparam int PROD_W   = FORCE_BITS + TRIG_W;
  localparam int ACC_W    = PROD_W + 1;

  // Rotation stages, applied in this order
  localparam int STAGES = 3;
  typedef logic [1:0] stage_t;
  localparam stage_t STAGE_PITCH = 2'd0;
  localparam stage_t STAGE_ROLL  = 2'd1;
  localparam stage_t STAGE_YAW   = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [FORCE_BITS-1:0] force_t;
  typedef logic signed [TRIG_W-1:0]     trig_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [ANGLE_FIELD_W-1:0]     angle_t;

  // One queued item: angles already masked and folded into +-90 degrees,
  // indexed by stage
  typedef struct packed {
    force_t                  fx;
    force_t                  fy;
    force_t                  fz;
    logic [STAGES-1:0][ANGLE_FIELD_W-1:0] ang;
    logic [STAGES-1:0]       flip;
    logic                    frame_end;
  } item_t;

  typedef struct packed {
    logic   start;
    angle_t angle;
    logic   flip;
  } cordic_req_t;

  typedef struct packed {
    logic  done;
    trig_t cos_v;
    trig_t sin_v;
  } cordic_rsp_t;

  function automatic logic signed [CORDIC_W-1:0] atan_turn(
      input logic [STEP_IDX_W-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      5'd0:    v = 33'sd536870912;
      5'd1:    v = 33'sd316933406;
      5'd2:    v = 33'sd167458907;
      5'd3:    v = 33'sd85004756;
      5'd4:    v = 33'sd42667331;
      5'd5:    v = 33'sd21354465;
      5'd6:    v = 33'sd10679838;
      5'd7:    v = 33'sd5340245;
      5'd8:    v = 33'sd2670163;
      5'd9:    v = 33'sd1335087;
      5'd10:   v = 33'sd667544;
      5'd11:   v = 33'sd333772;
      5'd12:   v = 33'sd166886;
      5'd13:   v = 33'sd83443;
      5'd14:   v = 33'sd41722;
      5'd15:   v = 33'sd20861;
      5'd16:   v = 33'sd10430;
      5'd17:   v = 33'sd5215;
      5'd18:   v = 33'sd2608;
      5'd19:   v = 33'sd1304;
      5'd20:   v = 33'sd652;
      5'd21:   v = 33'sd326;
      5'd22:   v = 33'sd163;
      5'd23:   v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/efra_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_front: input acceptance and angle folding
// Unpacks each input transaction, folds every angle into +-90 degrees and
// parks the record in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module efra_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [efra_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            q_valid,
  output efra_pkg::item_t                 q_item,
  input  logic                            q_pop
);
  import efra_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  item_t             in_item;
  angle_t            raw_ang [STAGES];
  logic              push;

  always_comb begin
    raw_ang[STAGE_PITCH] = in_tdata[IN_PITCH_LSB +: ANGLE_FIELD_W] & ANGLE_KEEP;
    raw_ang[STAGE_ROLL]  = in_tdata[IN_ROLL_LSB +: ANGLE_FIELD_W] & ANGLE_KEEP;
    raw_ang[STAGE_YAW]   = in_tdata[IN_YAW_LSB +: ANGLE_FIELD_W] & ANGLE_KEEP;
    in_item.fx        = in_tdata[IN_FX_LSB +: FORCE_BITS];
    in_item.fy        = in_tdata[IN_FY_LSB +: FORCE_BITS];
    in_item.fz        = in_tdata[IN_FZ_LSB +: FORCE_BITS];
    in_item.frame_end = in_tlast;
    // Fold the back half circle by half a turn; cos/sin negate later
    for (int s = 0; s < STAGES; s++) begin
      in_item.flip[s] = raw_ang[s][ANGLE_FIELD_W-1] ^ raw_ang[s][ANGLE_FIELD_W-2];
      in_item.ang[s]  = {raw_ang[s][ANGLE_FIELD_W-1] ^ in_item.flip[s],
                         raw_ang[s][ANGLE_FIELD_W-2:0]};
    end
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid & in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/efra_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_cordic: iterative sine/cosine unit
// Runs two CORDIC micro-rotations per cycle, then rounds to the trig format
// and undoes the half-turn fold.
// ----------------------------------------------------------------------------
module efra_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  efra_pkg::cordic_req_t req,
  output efra_pkg::cordic_rsp_t rsp
);
  import efra_pkg::*;

  logic                         run_r, rnd_r, done_r, flip_r;
  logic [CYC_CNT_W-1:0]         k_r;
  logic signed [CORDIC_W-1:0]   x_r, y_r, z_r;
  logic signed [CORDIC_W-1:0]   x1, y1, z1, x2, y2, z2;
  logic signed [CORDIC_W-1:0]   xr, yr;
  logic [STEP_IDX_W-1:0]        i0, i1;
  trig_t                        cos_r, sin_r, cos_q, sin_q;

  always_comb begin
    i0 = STEP_IDX_W'({k_r, 1'b0});
    i1 = STEP_IDX_W'({k_r, 1'b1});
    if (!z_r[CORDIC_W-1]) begin
      x1 = x_r - (y_r >>> i0);
      y1 = y_r + (x_r >>> i0);
      z1 = z_r - atan_turn(i0);
    end else begin
      x1 = x_r + (y_r >>> i0);
      y1 = y_r - (x_r >>> i0);
      z1 = z_r + atan_turn(i0);
    end
    if (!z1[CORDIC_W-1]) begin
      x2 = x1 - (y1 >>> i1);
      y2 = y1 + (x1 >>> i1);
      z2 = z1 - atan_turn(i1);
    end else begin
      x2 = x1 + (y1 >>> i1);
      y2 = y1 - (x1 >>> i1);
      z2 = z1 + atan_turn(i1);
    end
    // Round half up and drop to the trig format
    xr    = (x_r + TRIG_HALF) >>> TRIG_SHIFT;
    yr    = (y_r + TRIG_HALF) >>> TRIG_SHIFT;
    cos_q = flip_r ? -xr[TRIG_W-1:0] : xr[TRIG_W-1:0];
    sin_q = flip_r ? -yr[TRIG_W-1:0] : yr[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= CORDIC_W'($signed({req.angle, 16'h0000}));
      flip_r <= req.flip;
    end else if (run_r) begin
      x_r <= x2;
      y_r <= y2;
      z_r <= z2;
    end
    if (rnd_r) begin
      cos_r <= cos_q;
      sin_r <= sin_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= rnd_r;
      rnd_r  <= run_r && !req.start && (k_r == CYC_CNT_W'(CORDIC_CYCLES - 1));
      if (req.start) begin
        run_r <= 1'b1;
        k_r   <= '0;
      end else if (run_r) begin
        k_r <= k_r + CYC_CNT_W'(1);
        if (k_r == CYC_CNT_W'(CORDIC_CYCLES - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = cos_r;
  assign rsp.sin_v = sin_r;

endmodule

FILE: rtl/core/efra_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_back: rotation sequencer and accumulator
// Pops one item, runs pitch, roll and yaw through the shared CORDIC and a
// pair of multipliers, updates the running sums and fills the result register.
// ----------------------------------------------------------------------------
module efra_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  efra_pkg::item_t                 q_item,
  output logic                            q_pop,
  output efra_pkg::cordic_req_t           cordic_req,
  input  efra_pkg::cordic_rsp_t           cordic_rsp,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [efra_pkg::OUT_DATA_W-1:0] out_tdata
);
  import efra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_MUL_A, S_MUL_B, S_MUL_C, S_ACC
  } state_t;

  localparam logic signed [ACC_W-1:0] F_MAX =
      $signed((ACC_W'(1) << (FORCE_BITS - 1)) - ACC_W'(1));
  localparam logic signed [ACC_W-1:0] F_MIN = -F_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (ROT_FRAC - 1);
  localparam logic signed [SUM_BITS:0] S_MAX =
      $signed(((SUM_BITS + 1)'(1) << (SUM_BITS - 1)) - (SUM_BITS + 1)'(1));
  localparam logic signed [SUM_BITS:0] S_MIN = -S_MAX - (SUM_BITS + 1)'(1);
  localparam sum_t O_MAX = $signed((SUM_BITS'(1) << (OUT_W - 1)) - SUM_BITS'(1));
  localparam sum_t O_MIN = -O_MAX - SUM_BITS'(1);

  state_t                          state_r;
  stage_t                          stage_r;
  force_t                          vx_r, vy_r, vz_r, anew_r;
  logic [STAGES-1:0][ANGLE_FIELD_W-1:0] ang_r;
  logic [STAGES-1:0]               flip_r;
  logic                            fend_r;
  prod_t                           p0_r, p1_r;
  sum_t                            sum_x_r, sum_y_r, sum_z_r;
  logic                            out_valid_r;
  logic [OUT_DATA_W-1:0]           out_data_r;

  force_t                          op_a, op_b, bnew, mul_a, mul_b;
  prod_t                           p_cos, p_sin;
  sum_t                            nsum_x, nsum_y, nsum_z;
  logic                            acc_go;

  // Round half up, drop the trig fraction, clamp to the force range
  function automatic force_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + RND_HALF) >>> ROT_FRAC;
    if (t > F_MAX) begin
      t = F_MAX;
    end else if (t < F_MIN) begin
      t = F_MIN;
    end
    return t[FORCE_BITS-1:0];
  endfunction

  function automatic sum_t sat_add(input sum_t a, input force_t b);
    logic signed [SUM_BITS:0] t;
    t = (SUM_BITS + 1)'(a) + (SUM_BITS + 1)'(b);
    if (t > S_MAX) begin
      t = S_MAX;
    end else if (t < S_MIN) begin
      t = S_MIN;
    end
    return t[SUM_BITS-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input sum_t v);
    sum_t t;
    t = v;
    if (t > O_MAX) begin
      t = O_MAX;
    end else if (t < O_MIN) begin
      t = O_MIN;
    end
    return t[OUT_W-1:0];
  endfunction

  // Each stage rotates a pair (a, b): a' = a*c - b*s, b' = b*c + a*s
  always_comb begin
    case (stage_r)
      STAGE_PITCH: begin
        op_a = vy_r;
        op_b = vz_r;
      end
      STAGE_ROLL: begin
        op_a = vx_r;
        op_b = vy_r;
      end
      STAGE_YAW: begin
        op_a = vz_r;
        op_b = vx_r;
      end
      default: begin
        op_a = vx_r;
        op_b = vy_r;
      end
    endcase
    // S_MUL_A forms a*c and b*s, S_MUL_B forms b*c and a*s
    mul_a = (state_r == S_MUL_A) ? op_a : op_b;
    mul_b = (state_r == S_MUL_A) ? op_b : op_a;
    p_cos = PROD_W'(mul_a) * PROD_W'(cordic_rsp.cos_v);
    p_sin = PROD_W'(mul_b) * PROD_W'(cordic_rsp.sin_v);
    bnew  = round_sat(ACC_W'(p0_r) + ACC_W'(p1_r));

    nsum_x = sat_add(sum_x_r, vx_r);
    nsum_y = sat_add(sum_y_r, vy_r);
    nsum_z = sat_add(sum_z_r, vz_r);
    acc_go = (state_r == S_ACC) && (!out_valid_r || out_tready);

    q_pop = (state_r == S_IDLE) && q_valid;

    // Launch the first trig from the queue head, later ones from the item regs
    cordic_req.start = q_pop || ((state_r == S_MUL_C) && (stage_r != STAGE_YAW));
    if (state_r == S_IDLE) begin
      cordic_req.angle = q_item.ang[STAGE_PITCH];
      cordic_req.flip  = q_item.flip[STAGE_PITCH];
    end else begin
      cordic_req.angle = ang_r[stage_r + stage_t'(1)];
      cordic_req.flip  = flip_r[stage_r + stage_t'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= STAGE_PITCH;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !acc_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            vx_r    <= q_item.fx;
            vy_r    <= q_item.fy;
            vz_r    <= q_item.fz;
            ang_r   <= q_item.ang;
            flip_r  <= q_item.flip;
            fend_r  <= q_item.frame_end;
            stage_r <= STAGE_PITCH;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (cordic_rsp.done) begin
            state_r <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          p0_r    <= p_cos;
          p1_r    <= p_sin;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          anew_r  <= round_sat(ACC_W'(p0_r) - ACC_W'(p1_r));
          p0_r    <= p_cos;
          p1_r    <= p_sin;
          state_r <= S_MUL_C;
        end
        S_MUL_C: begin
          case (stage_r)
            STAGE_PITCH: begin
              vy_r <= anew_r;
              vz_r <= bnew;
            end
            STAGE_ROLL: begin
              vx_r <= anew_r;
              vy_r <= bnew;
            end
            default: begin
              vz_r <= anew_r;
              vx_r <= bnew;
            end
          endcase
          if (stage_r == STAGE_YAW) begin
            state_r <= S_ACC;
          end else begin
            stage_r <= stage_r + stage_t'(1);
            state_r <= S_WAIT;
          end
        end
        S_ACC: begin
          if (acc_go) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {sat_out(nsum_z), sat_out(nsum_y), sat_out(nsum_x),
                            OUT_W'(vz_r), OUT_W'(vy_r), OUT_W'(vx_r)};
            // Report the sum with this item, then clear on a frame end
            sum_x_r <= fend_r ? '0 : nsum_x;
            sum_y_r <= fend_r ? '0 : nsum_y;
            sum_z_r <= fend_r ? '0 : nsum_z;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/euler_force_rotate_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_force_rotate_accumulate: body-to-world force rotation with running sum
// Rotates each force by pitch (about X), roll (about Z) and yaw (about Y),
// returns the rotated vector and the saturated running world-force sum.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: force xyz, pitch, yaw, roll;
//          |     |                    | tlast: frame end (clear sum after)
//  out_    | out | out_tvalid/tready  | tdata: rotated xyz, total xyz
//
// Each item is loaded at queue pop, then runs three rotation stages, each set
// by the shared CORDIC unit (double-step iterations, then rounding) plus the
// multiply pair, and is then accumulated. A two-entry queue lets the input
// keep taking transactions while the back end works; the result register
// holds a finished result while the next item is already being rotated.
// Reset (rst_n low, synchronous) clears the running sums, the queue and all
// handshake state.
// ----------------------------------------------------------------------------
module euler_force_rotate_accumulate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // force_x[31:0], force_y[63:32], force_z[95:64], pitch_angle[111:96],
  // yaw_angle[127:112], roll_angle[143:128]
  input  logic [efra_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,   // frame_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rotated_x[31:0], rotated_y[63:32], rotated_z[95:64],
  // total_x[127:96], total_y[159:128], total_z[191:160]
  output logic [efra_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import efra_pkg::*;

  logic        q_valid;
  logic        q_pop;
  item_t       q_item;
  cordic_req_t cordic_req;
  cordic_rsp_t cordic_rsp;

  // Front: accept transactions, fold angles, queue them
  efra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // Shared sine/cosine unit, one angle at a time
  efra_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  // Back: sequence the three rotations, accumulate, hold the result
  efra_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cordic_req (cordic_req),
    .cordic_rsp (cordic_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
